### design/arpcr_pkg.sv
// Package for the ARP cache and responder: widths, protocol constants,
// controller/datapath command and status types. No dependencies.
package arpcr_pkg;

    // Field widths
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int ENTRY_W   = IP_W + MAC_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 48;

    // Default cache depth
    localparam int DEFAULT_CACHE_ENTRIES = 16;

    // Item kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_PACKET = 1'b1;

    // ARP header values that a packet must carry, and the request opcode
    localparam logic [15:0] HTYPE_ETH        = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4       = 16'h0800;
    localparam logic [7:0]  HLEN_MAC         = 8'd6;
    localparam logic [7:0]  PLEN_IPV4        = 8'd4;
    localparam logic [15:0] PKT_OPER_REQUEST = 16'h0001;

    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // Frame operation codes on the result
    localparam logic [1:0] OPER_NONE    = 2'd0;
    localparam logic [1:0] OPER_REQUEST = 2'd1;
    localparam logic [1:0] OPER_REPLY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 8'd1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming transaction, restart the scan
        logic issue;    // read the next cache entry
        logic commit;   // update the cache and load the result register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_bad;     // incoming transaction is a packet with a bad header
        logic last_addr;  // scan counter sits on the last entry
        logic out_free;   // result register can take a new result
    } dp_status_t;

endpackage

### design/arp_cache_and_responder.sv
// ARP cache and responder, top level. Depends on arpcr_pkg, arpcr_ctrl, arpcr_dp.
// A transaction is captured, then the entry RAM is scanned one entry per cycle and
// the result committed; a packet with a bad header skips the scan. A new
// transaction is accepted only after the result of the last one is loaded;
// a stalled result holds off the next accept.
// Reset clears all entry flags, the replacement pointer and the config registers.
module arp_cache_and_responder #(
    parameter int CACHE_ENTRIES = arpcr_pkg::DEFAULT_CACHE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arpcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arpcr_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            req_type,
    input  logic [arpcr_pkg::IP_W-1:0]      query_ip,
    input  logic [15:0]                     pkt_htype,
    input  logic [15:0]                     pkt_ptype,
    input  logic [7:0]                      pkt_hlen,
    input  logic [7:0]                      pkt_plen,
    input  logic [15:0]                     pkt_oper,
    input  logic [arpcr_pkg::MAC_W-1:0]     sender_mac,
    input  logic [arpcr_pkg::IP_W-1:0]      sender_ip,
    input  logic [arpcr_pkg::IP_W-1:0]      target_ip,
    // result channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            lookup_hit,
    output logic [arpcr_pkg::MAC_W-1:0]     lookup_mac,
    output logic                            send_frame,
    output logic [1:0]                      frame_oper,
    output logic [arpcr_pkg::MAC_W-1:0]     frame_dest_mac,
    output logic [arpcr_pkg::MAC_W-1:0]     frame_target_mac,
    output logic [arpcr_pkg::IP_W-1:0]      frame_target_ip
);

    import arpcr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Config registers accept every transaction
    assign cfg_ready = 1'b1;

    // Controller
    arpcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    arpcr_dp #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .query_ip         (query_ip),
        .pkt_htype        (pkt_htype),
        .pkt_ptype        (pkt_ptype),
        .pkt_hlen         (pkt_hlen),
        .pkt_plen         (pkt_plen),
        .pkt_oper         (pkt_oper),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_ip        (target_ip),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .lookup_hit       (lookup_hit),
        .lookup_mac       (lookup_mac),
        .send_frame       (send_frame),
        .frame_oper       (frame_oper),
        .frame_dest_mac   (frame_dest_mac),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip)
    );

    // Accepted transaction blocks the request channel until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while a transaction is in flight");

    // Commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result register overwritten");

    // Frame flag agrees with the frame operation
    a_frame_oper: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (send_frame == (frame_oper != OPER_NONE)))
        else $error("send_frame and frame_oper disagree");

    // A hit never comes with a frame
    a_hit_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && lookup_hit) |-> !send_frame)
        else $error("lookup hit with a frame");

endmodule

### design/arpcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module arpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/arpcr_ctrl.sv
// Controller for the ARP cache: sequences capture, entry scan and commit.
// Depends on arpcr_pkg.
module arpcr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  arpcr_pkg::dp_status_t  status,
    output arpcr_pkg::ctrl_cmd_t   cmd
);

    import arpcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    // bad header: nothing to search, go straight to result
                    state_next = status.in_bad ? ST_COMMIT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        req_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_SEARCH:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/arpcr_dp.sv
// Datapath for the ARP cache: transaction registers, entry flags, entry RAM,
// scan compare, replacement pointer, config registers and result register.
// Depends on arpcr_pkg and arpcr_ram.
module arpcr_dp #(
    parameter int CACHE_ENTRIES = arpcr_pkg::DEFAULT_CACHE_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command / status
    input  arpcr_pkg::ctrl_cmd_t           cmd,
    output arpcr_pkg::dp_status_t          status,
    // config
    input  logic                           cfg_valid,
    input  logic [arpcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arpcr_pkg::CFG_W-1:0]    cfg_data,
    // incoming fields
    input  logic                           req_type,
    input  logic [arpcr_pkg::IP_W-1:0]     query_ip,
    input  logic [15:0]                    pkt_htype,
    input  logic [15:0]                    pkt_ptype,
    input  logic [7:0]                     pkt_hlen,
    input  logic [7:0]                     pkt_plen,
    input  logic [15:0]                    pkt_oper,
    input  logic [arpcr_pkg::MAC_W-1:0]    sender_mac,
    input  logic [arpcr_pkg::IP_W-1:0]     sender_ip,
    input  logic [arpcr_pkg::IP_W-1:0]     target_ip,
    // result
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           lookup_hit,
    output logic [arpcr_pkg::MAC_W-1:0]    lookup_mac,
    output logic                           send_frame,
    output logic [1:0]                     frame_oper,
    output logic [arpcr_pkg::MAC_W-1:0]    frame_dest_mac,
    output logic [arpcr_pkg::MAC_W-1:0]    frame_target_mac,
    output logic [arpcr_pkg::IP_W-1:0]     frame_target_ip
);

    import arpcr_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // Config registers
    logic [MAC_W-1:0] own_mac_reg;
    logic [IP_W-1:0]  own_ip_reg;

    // Transaction registers
    logic             type_reg;
    logic             skip_reg;
    logic             oper_req_reg;
    logic [IP_W-1:0]  key_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  tip_reg;

    // Entry flags and replacement pointer
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [CACHE_ENTRIES-1:0] known_reg;
    logic [IDX_W-1:0]         ptr_reg;

    // Scan state
    logic [IDX_W-1:0] cnt_reg;
    logic             p_vld_reg;
    logic [IDX_W-1:0] p_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [MAC_W-1:0] hit_mac_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Result register
    logic             rsp_valid_reg;
    logic             lookup_hit_reg;
    logic [MAC_W-1:0] lookup_mac_reg;
    logic             send_frame_reg;
    logic [1:0]       frame_oper_reg;
    logic [MAC_W-1:0] frame_dest_mac_reg;
    logic [MAC_W-1:0] frame_target_mac_reg;
    logic [IP_W-1:0]  frame_target_ip_reg;

    // RAM and commit signals
    logic [ENTRY_W-1:0] rd_data;
    logic [IP_W-1:0]    rd_ip;
    logic [MAC_W-1:0]   rd_mac;
    logic               in_hdr_ok;
    logic               match;
    logic               free_slot;
    logic [IDX_W-1:0]   alloc_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic               do_write;
    logic               adv_ptr;
    logic [MAC_W-1:0]   wr_mac;
    logic               res_hit;
    logic               res_req;
    logic               res_reply;

    // Status back to the controller
    assign in_hdr_ok = (pkt_htype == HTYPE_ETH) && (pkt_ptype == PTYPE_IPV4) &&
                       (pkt_hlen == HLEN_MAC) && (pkt_plen == PLEN_IPV4);
    assign status.in_bad    = (req_type == REQ_PACKET) && !in_hdr_ok;
    assign status.last_addr = (cnt_reg == LAST_IDX);
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data[MAC_W-1:0];
            end
            else if (cfg_index == CFG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[IP_W-1:0];
            end
        end
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg     <= req_type;
            skip_reg     <= status.in_bad;
            oper_req_reg <= (pkt_oper == PKT_OPER_REQUEST);
            key_reg      <= (req_type == REQ_PACKET) ? sender_ip : query_ip;
            smac_reg     <= sender_mac;
            tip_reg      <= target_ip;
        end
    end

    // Entry RAM: {ip, mac}
    arpcr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CACHE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_idx),
        .wr_data ({key_reg, wr_mac}),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    assign rd_ip  = rd_data[ENTRY_W-1:MAC_W];
    assign rd_mac = rd_data[MAC_W-1:0];

    // Compare stage: one entry per cycle, RAM data lines up with p_idx
    assign match     = p_vld_reg && valid_reg[p_idx_reg] && (rd_ip == key_reg);
    assign free_slot = p_vld_reg && !valid_reg[p_idx_reg];

    // Scan counter and first-match / first-free latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            p_vld_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= cmd.issue;
            if (cmd.capture)
            begin
                cnt_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue && !status.last_addr)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_slot && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Scan payload
    always_ff @(posedge clk)
    begin
        p_idx_reg <= cnt_reg;
        if (match && !hit_reg)
        begin
            hit_idx_reg <= p_idx_reg;
            hit_mac_reg <= rd_mac;
        end
        if (free_slot && !free_found_reg)
        begin
            free_idx_reg <= p_idx_reg;
        end
    end

    // Commit decision
    always_comb
    begin
        alloc_idx = free_found_reg ? free_idx_reg : ptr_reg;
        wr_idx    = hit_reg ? hit_idx_reg : alloc_idx;
        do_write  = cmd.commit && !skip_reg && ((type_reg == REQ_PACKET) || !hit_reg);
        adv_ptr   = do_write && !hit_reg && !free_found_reg;
        wr_mac    = (type_reg == REQ_PACKET) ? smac_reg : '0;
        res_hit   = (type_reg == REQ_LOOKUP) && hit_reg && known_reg[hit_idx_reg];
        res_req   = (type_reg == REQ_LOOKUP) && !hit_reg;
        res_reply = (type_reg == REQ_PACKET) && !skip_reg && oper_req_reg &&
                    (tip_reg == own_ip_reg);
    end

    // Entry flags and round-robin pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            known_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            if (do_write)
            begin
                valid_reg[wr_idx] <= 1'b1;
                known_reg[wr_idx] <= (type_reg == REQ_PACKET);
            end
            if (adv_ptr)
            begin
                ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            lookup_hit_reg <= res_hit;
            lookup_mac_reg <= res_hit ? hit_mac_reg : '0;
            priority if (res_req)
            begin
                send_frame_reg       <= 1'b1;
                frame_oper_reg       <= OPER_REQUEST;
                frame_dest_mac_reg   <= BCAST_MAC;
                frame_target_mac_reg <= '0;
                frame_target_ip_reg  <= key_reg;
            end
            else if (res_reply)
            begin
                send_frame_reg       <= 1'b1;
                frame_oper_reg       <= OPER_REPLY;
                frame_dest_mac_reg   <= smac_reg;
                frame_target_mac_reg <= smac_reg;
                frame_target_ip_reg  <= key_reg;
            end
            else
            begin
                send_frame_reg       <= 1'b0;
                frame_oper_reg       <= OPER_NONE;
                frame_dest_mac_reg   <= '0;
                frame_target_mac_reg <= '0;
                frame_target_ip_reg  <= '0;
            end
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign lookup_hit       = lookup_hit_reg;
    assign lookup_mac       = lookup_mac_reg;
    assign send_frame       = send_frame_reg;
    assign frame_oper       = frame_oper_reg;
    assign frame_dest_mac   = frame_dest_mac_reg;
    assign frame_target_mac = frame_target_mac_reg;
    assign frame_target_ip  = frame_target_ip_reg;

endmodule

### dv/arpcr_checker.sv
`timescale 1ns / 100ps
// Checker for the ARP cache and responder: snoops the register, request and result
// channels, keeps its own copy of the cache and compares every result. Needs arpcr_pkg.
module arpcr_checker
    import arpcr_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  logic                 req_type,
    input  logic [IP_W-1:0]      query_ip,
    input  logic [15:0]          pkt_htype,
    input  logic [15:0]          pkt_ptype,
    input  logic [7:0]           pkt_hlen,
    input  logic [7:0]           pkt_plen,
    input  logic [15:0]          pkt_oper,
    input  logic [MAC_W-1:0]     sender_mac,
    input  logic [IP_W-1:0]      sender_ip,
    input  logic [IP_W-1:0]      target_ip,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  logic                 lookup_hit,
    input  logic [MAC_W-1:0]     lookup_mac,
    input  logic                 send_frame,
    input  logic [1:0]           frame_oper,
    input  logic [MAC_W-1:0]     frame_dest_mac,
    input  logic [MAC_W-1:0]     frame_target_mac,
    input  logic [IP_W-1:0]      frame_target_ip,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic             send;
        logic [1:0]       oper;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] tgt_mac;
        logic [IP_W-1:0]  tgt_ip;
    } arp_result_t;

    // Shadow copy of the cache and the station registers
    logic             slot_used  [CACHE_ENTRIES];
    logic             slot_known [CACHE_ENTRIES];
    logic [IP_W-1:0]  slot_ip    [CACHE_ENTRIES];
    logic [MAC_W-1:0] slot_mac   [CACHE_ENTRIES];
    int               victim_ptr;
    logic [MAC_W-1:0] station_mac;
    logic [IP_W-1:0]  station_ip;

    arp_result_t expected_q[$];
    int          errors;

    // Valid slot holding ip, or -1
    function automatic int find_slot(logic [IP_W-1:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (slot_used[i] && slot_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // Lowest free slot, else the round-robin victim
    function automatic int claim_slot();
        int victim;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!slot_used[i])
                return i;
        victim = victim_ptr;
        victim_ptr = (victim_ptr + 1) % CACHE_ENTRIES;
        return victim;
    endfunction

    // Update the shadow cache for the transaction on the request port, return its result
    function automatic arp_result_t resolve_request();
        arp_result_t r;
        int          e;
        r = '0;
        if (req_type == REQ_LOOKUP) begin
            e = find_slot(query_ip);
            if (e >= 0) begin
                if (slot_known[e]) begin
                    r.hit = 1'b1;
                    r.mac = slot_mac[e];
                end
            end
            else begin
                // miss: park a pending entry and broadcast a request
                e = claim_slot();
                slot_used[e]  = 1'b1;
                slot_known[e] = 1'b0;
                slot_ip[e]    = query_ip;
                slot_mac[e]   = '0;
                r.send     = 1'b1;
                r.oper     = OPER_REQUEST;
                r.dest_mac = BCAST_MAC;
                r.tgt_ip   = query_ip;
            end
        end
        else if (pkt_htype == HTYPE_ETH && pkt_ptype == PTYPE_IPV4 &&
                 pkt_hlen == HLEN_MAC && pkt_plen == PLEN_IPV4) begin
            // good header: learn the sender, answer requests for our address
            e = find_slot(sender_ip);
            if (e < 0)
                e = claim_slot();
            slot_used[e]  = 1'b1;
            slot_known[e] = 1'b1;
            slot_ip[e]    = sender_ip;
            slot_mac[e]   = sender_mac;
            if (pkt_oper == PKT_OPER_REQUEST && target_ip == station_ip) begin
                r.send     = 1'b1;
                r.oper     = OPER_REPLY;
                r.dest_mac = sender_mac;
                r.tgt_mac  = sender_mac;
                r.tgt_ip   = sender_ip;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arp_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_known[i] = 1'b0;
                slot_ip[i]    = '0;
                slot_mac[i]   = '0;
            end
            victim_ptr  = 0;
            station_mac = '0;
            station_ip  = '0;
            errors      = 0;
            expected_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OWN_MAC)
                    station_mac = cfg_data[MAC_W-1:0];
                else if (cfg_index == CFG_OWN_IP)
                    station_ip = cfg_data[IP_W-1:0];
            end

            // result transaction against the oldest expectation
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("lookup_hit", 64'(want.hit), 64'(lookup_hit));
                    check_field("lookup_mac", 64'(want.mac), 64'(lookup_mac));
                    check_field("send_frame", 64'(want.send), 64'(send_frame));
                    check_field("frame_oper", 64'(want.oper), 64'(frame_oper));
                    check_field("frame_dest_mac", 64'(want.dest_mac), 64'(frame_dest_mac));
                    check_field("frame_target_mac", 64'(want.tgt_mac),
                                64'(frame_target_mac));
                    check_field("frame_target_ip", 64'(want.tgt_ip), 64'(frame_target_ip));
                end
            end

            // request transaction
            if (req_valid && !req_stall)
                expected_q.push_back(resolve_request());

            fail_count    <= errors;
            pending_count <= expected_q.size();
        end
    end

endmodule

### dv/tb_arp_cache_and_responder.sv
`timescale 1ns / 100ps
// Top of the ARP cache and responder bench: clock, reset, register writes and
// transaction stimulus. Needs arpcr_pkg, arpcr_checker and the block itself.
module tb_arp_cache_and_responder;
    import arpcr_pkg::*;

    localparam int              POOL_SIZE      = 22;
    localparam int              PHASES         = 4;
    localparam int              PHASE_ITEMS    = 150;
    localparam int              SETTLE_CYCLES  = 25;
    localparam int              TAIL_CYCLES    = 40;
    localparam logic [15:0]     PKT_OPER_REPLY = 16'h0002;
    localparam logic [IP_W-1:0] ALL_IP         = '1;
    localparam logic [MAC_W-1:0] ALL_MAC       = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP   = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    logic                 req_type;
    logic [IP_W-1:0]      query_ip;
    logic [15:0]          pkt_htype;
    logic [15:0]          pkt_ptype;
    logic [7:0]           pkt_hlen;
    logic [7:0]           pkt_plen;
    logic [15:0]          pkt_oper;
    logic [MAC_W-1:0]     sender_mac;
    logic [IP_W-1:0]      sender_ip;
    logic [IP_W-1:0]      target_ip;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic                 lookup_hit;
    logic [MAC_W-1:0]     lookup_mac;
    logic                 send_frame;
    logic [1:0]           frame_oper;
    logic [MAC_W-1:0]     frame_dest_mac;
    logic [MAC_W-1:0]     frame_target_mac;
    logic [IP_W-1:0]      frame_target_ip;
    int                   fail_count;
    int                   pending_count;

    logic                 calm = 1'b0;
    logic [IP_W-1:0]      own_ip_now;
    logic [IP_W-1:0]      ip_pool [POOL_SIZE];
    int                   n_lookups, n_packets, n_broken, n_settings;

    arp_cache_and_responder DUT (.*);

    arpcr_checker u_checker (.*);

    always #6 clk = ~clk;

    // result side backpressure
    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(99) < 9);

    // watchdog
    initial
    begin
        #(12 * 400_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly a small address set, so the table fills and entries get evicted
    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(99) < 85)
            return ip_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_IP)
            own_ip_now = val[IP_W-1:0];
        @(posedge clk);
    endtask

    // hold the request side until every result is back
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic send_txn(input logic kind, input logic [IP_W-1:0] qip,
                            input logic [15:0] ht, input logic [15:0] pt,
                            input logic [7:0] hl, input logic [7:0] pl,
                            input logic [15:0] op, input logic [MAC_W-1:0] smac,
                            input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
        if (!calm)
            while ($urandom_range(99) < 9)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid  <= 1'b1;
        req_type   <= kind;
        query_ip   <= qip;
        pkt_htype  <= ht;
        pkt_ptype  <= pt;
        pkt_hlen   <= hl;
        pkt_plen   <= pl;
        pkt_oper   <= op;
        sender_mac <= smac;
        sender_ip  <= sip;
        target_ip  <= tip;
        do @(posedge clk); while (req_stall);
    endtask

    // lookup with random filler in the packet fields
    task automatic lookup(input logic [IP_W-1:0] ip);
        n_lookups++;
        send_txn(REQ_LOOKUP, ip, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), rand_mac(), $urandom, $urandom);
    endtask

    // received packet with a random, unused query address
    task automatic packet(input logic [15:0] ht, input logic [15:0] pt, input logic [7:0] hl,
                          input logic [7:0] pl, input logic [15:0] op,
                          input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                          input logic [IP_W-1:0] tip);
        n_packets++;
        if (ht != HTYPE_ETH || pt != PTYPE_IPV4 || hl != HLEN_MAC || pl != PLEN_IPV4)
            n_broken++;
        send_txn(REQ_PACKET, $urandom, ht, pt, hl, pl, op, smac, sip, tip);
    endtask

    task automatic good_packet(input logic [15:0] op, input logic [MAC_W-1:0] smac,
                               input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
        packet(HTYPE_ETH, PTYPE_IPV4, HLEN_MAC, PLEN_IPV4, op, smac, sip, tip);
    endtask

    task automatic random_txn();
        int               pick;
        logic [15:0]      ht, pt, op;
        logic [7:0]       hl, pl;
        logic [IP_W-1:0]  tip;
        pick = $urandom_range(99);
        if (pick < 45)
            lookup(pick_ip());
        else
        begin
            ht = HTYPE_ETH;
            pt = PTYPE_IPV4;
            hl = HLEN_MAC;
            pl = PLEN_IPV4;
            case ($urandom_range(9))
                0, 1, 2, 3: op = PKT_OPER_REQUEST;
                4, 5, 6, 7: op = PKT_OPER_REPLY;
                default:    op = 16'($urandom);
            endcase
            tip = $urandom_range(1) ? own_ip_now : pick_ip();
            // a tenth of all traffic carries a damaged header
            if (pick >= 90)
                case ($urandom_range(4))
                    0: ht = 16'($urandom);
                    1: pt = 16'($urandom);
                    2: hl = 8'($urandom);
                    3: pl = 8'($urandom);
                    default:
                    begin
                        ht = 16'($urandom);
                        pt = 16'($urandom);
                        hl = 8'($urandom);
                        pl = 8'($urandom);
                    end
                endcase
            packet(ht, pt, hl, pl, op, rand_mac(), pick_ip(), tip);
        end
    endtask

    initial
    begin
        logic [IP_W-1:0]  ip_a, ip_b, ip_c;
        logic [CFG_W-1:0] setting;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        req_valid  = 1'b0;
        req_type   = REQ_LOOKUP;
        query_ip   = '0;
        pkt_htype  = '0;
        pkt_ptype  = '0;
        pkt_hlen   = '0;
        pkt_plen   = '0;
        pkt_oper   = '0;
        sender_mac = '0;
        sender_ip  = '0;
        target_ip  = '0;
        own_ip_now = '0;
        n_lookups  = 0;
        n_packets  = 0;
        n_broken   = 0;
        n_settings = 0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = ALL_IP;
        ip_a = $urandom;
        ip_b = ip_a ^ 32'h0000_0100;
        ip_c = ~ip_a;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        write_reg(CFG_OWN_MAC, rand_mac());
        write_reg(CFG_OWN_IP, {16'($urandom), 32'($urandom)});
        n_settings++;

        lookup('0);                                            // miss, broadcast request
        lookup('0);                                            // pending, nothing sent
        lookup(ALL_IP);                                        // miss at the top address
        good_packet(PKT_OPER_REPLY, ALL_MAC, '0, $urandom);    // resolves the pending entry
        lookup('0);                                            // hit
        good_packet(PKT_OPER_REQUEST, '0, ALL_IP, own_ip_now); // request for us: reply
        lookup(ALL_IP);                                        // hit with zero MAC
        good_packet(PKT_OPER_REQUEST, rand_mac(), ip_a, ~own_ip_now); // not for us
        good_packet(16'h0000, rand_mac(), ip_a, own_ip_now);   // unknown op still learns
        good_packet(16'hFFFF, rand_mac(), ip_b, own_ip_now);
        lookup(ip_a);
        lookup(ip_b);
        packet(16'h0000, PTYPE_IPV4, HLEN_MAC, PLEN_IPV4, PKT_OPER_REQUEST,
               rand_mac(), ip_c, own_ip_now);
        packet(16'hFFFF, PTYPE_IPV4, HLEN_MAC, PLEN_IPV4, PKT_OPER_REQUEST,
               rand_mac(), ip_c, own_ip_now);
        packet(HTYPE_ETH, 16'h0806, HLEN_MAC, PLEN_IPV4, PKT_OPER_REQUEST,
               rand_mac(), ip_c, own_ip_now);
        packet(HTYPE_ETH, PTYPE_IPV4, 8'h00, PLEN_IPV4, PKT_OPER_REQUEST,
               rand_mac(), ip_c, own_ip_now);
        packet(HTYPE_ETH, PTYPE_IPV4, HLEN_MAC, 8'hFF, PKT_OPER_REQUEST,
               rand_mac(), ip_c, own_ip_now);
        lookup(ip_c);                                          // broken packets learned nothing
        good_packet(PKT_OPER_REQUEST, rand_mac(), ip_c, own_ip_now);
        good_packet(PKT_OPER_REPLY, rand_mac(), '0, '0);       // overwrite in place
        lookup('0);
        lookup(ip_c);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (ph)
                0:
                begin
                    write_reg(CFG_OWN_MAC, '0);
                    write_reg(CFG_OWN_IP, '0);
                end
                1:
                begin
                    write_reg(CFG_OWN_MAC, '1);
                    write_reg(CFG_OWN_IP, '1);
                end
                default:
                begin
                    // writes past the last register must be ignored
                    write_reg(CFG_SPARE, rand_mac());
                    write_reg(CFG_TOP, rand_mac());
                    setting = rand_mac();
                    write_reg(CFG_OWN_MAC, setting);
                    write_reg(CFG_OWN_IP, ~setting);
                end
            endcase
            n_settings++;
            calm <= (ph == PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                random_txn();
                if ($urandom_range(99) == 0)
                    drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d lookups and %0d received packets (%0d with damaged headers)",
                 n_lookups, n_packets, n_broken);
        $display("under %0d register settings, with table overflow and replacement.",
                 n_settings);
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### arp_cache_and_responder.f
design/arpcr_pkg.sv
design/arpcr_ram.sv
design/arpcr_ctrl.sv
design/arpcr_dp.sv
design/arp_cache_and_responder.sv
dv/arpcr_checker.sv
dv/tb_arp_cache_and_responder.sv
